FILE: rtl/fpba_pkg.sv
// shared types and constants for the fit-policy block allocator
package fpba_pkg;

    // widths fixed by the request and result fields
    localparam int AMOUNT_W  = 16;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 1;
    // index carried along the chain, wide enough for the largest table
    localparam int TOK_IDX_W = 8;

    // request kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // fit policies
    localparam logic POLICY_FIRST = 1'b0;
    localparam logic POLICY_BEST  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b1;

    // reset value of the active block count
    localparam logic [COUNT_W-1:0] ACTIVE_RESET = 5'd16;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // search candidate travelling down the row of cells
    typedef struct packed {
        logic                  live;
        logic                  found;
        logic [TOK_IDX_W-1:0]  idx;
        logic [AMOUNT_W-1:0]   room;
    } scan_tok_t;

endpackage

FILE: rtl/fpba_cell.sv
// one table entry of the allocator with its stage of the search chain
module fpba_cell #(
    parameter int INDEX = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            live_en,
    input  logic                            policy,
    input  logic [fpba_pkg::AMOUNT_W-1:0]   need,
    input  logic                            wr_en,
    input  logic [fpba_pkg::AMOUNT_W-1:0]   wr_data,
    input  fpba_pkg::scan_tok_t             tok_in,
    output fpba_pkg::scan_tok_t             tok_out
);

    logic [fpba_pkg::AMOUNT_W-1:0] room_reg;
    fpba_pkg::scan_tok_t           tok_reg;
    fpba_pkg::scan_tok_t           tok_next;
    logic                          fits;
    logic                          better;
    logic                          take;

    assign fits   = (room_reg >= need);
    // strict compare keeps the lower index on a tie
    assign better = !tok_in.found
                    || ((policy == fpba_pkg::POLICY_BEST) && (room_reg < tok_in.room));
    assign take   = tok_in.live && live_en && fits && better;

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = fpba_pkg::TOK_IDX_W'(INDEX);
            tok_next.room  = room_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_en)
            begin
                room_reg <= wr_data;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/fit_policy_block_allocator_unit.sv
// top level of the fit-policy block allocator: control, row of cells, results
//
// usage
// - configuration: cfg_we writes cfg_data into register cfg_index (0 policy: 0
//   first/1 best fit; 1 active block count); user writes only while idle; not checked
// - a request is taken at a rising edge with start high and busy low
//   kind 0 loads amount into block slot, kind 1 asks for amount
// - every request gives exactly one result, shown for one cycle with done high;
//   granted, block_index and room_left are zero outside that cycle
// - a load answers in the cycle after it is taken and leaves busy low,
//   so loads can follow every cycle
// - an allocation passes the inject register, then the search candidate
//   moves one cell per cycle through all MAX_BLOCKS cells, then the chosen
//   cell is written back as the result is shown
// - busy falls in the cycle done is shown, so the next request can be taken
//   at the edge that ends it
// - reset clears all free sizes, selects first fit and sixteen active blocks
// - the receiver cannot stall; results must be taken when done is high
module fit_policy_block_allocator_unit #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpba_pkg::COUNT_W-1:0]        cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic [fpba_pkg::SLOT_W-1:0]         slot,
    input  logic [fpba_pkg::AMOUNT_W-1:0]       amount,
    output logic                                done,
    output logic                                granted,
    output logic [fpba_pkg::SLOT_W-1:0]         block_index,
    output logic [fpba_pkg::AMOUNT_W-1:0]       room_left
);

    fpba_pkg::state_t               state_reg;
    fpba_pkg::state_t               state_next;
    logic                           policy_reg;
    logic [fpba_pkg::COUNT_W-1:0]   active_reg;
    logic [fpba_pkg::AMOUNT_W-1:0]  need_reg;
    logic                           inject_reg;
    logic                           done_reg;
    logic                           done_next;
    logic                           granted_reg;
    logic                           granted_next;
    logic [fpba_pkg::SLOT_W-1:0]    block_index_reg;
    logic [fpba_pkg::SLOT_W-1:0]    block_index_next;
    logic [fpba_pkg::AMOUNT_W-1:0]  room_left_reg;
    logic [fpba_pkg::AMOUNT_W-1:0]  room_left_next;

    logic                           accept;
    logic                           load_we;
    logic                           alloc_go;
    logic                           write_back;
    logic [fpba_pkg::AMOUNT_W-1:0]  room_new;
    logic [fpba_pkg::AMOUNT_W-1:0]  wr_data;
    logic [MAX_BLOCKS-1:0]          live_bits;

    // tok[j] enters cell j, tok[MAX_BLOCKS] leaves the last cell
    fpba_pkg::scan_tok_t            tok [MAX_BLOCKS+1];
    fpba_pkg::scan_tok_t            tail;

    // fresh candidate enters the first cell the cycle after an allocation is taken
    always_comb
    begin
        tok[0]       = '0;
        tok[0].live  = inject_reg;
    end

    assign tail = tok[MAX_BLOCKS];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                if (alloc_go)
                begin
                    state_next = fpba_pkg::ST_SCAN;
                end
            end
            fpba_pkg::ST_SCAN:
            begin
                if (tail.live)
                begin
                    state_next = fpba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpba_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        busy     = 1'b0;
        unique case (state_reg)
            fpba_pkg::ST_IDLE: busy = 1'b0;
            fpba_pkg::ST_SCAN: busy = 1'b1;
            default:           busy = 1'b0;
        endcase
    end

    assign accept   = start && !busy;
    assign load_we  = accept && (kind == fpba_pkg::KIND_LOAD);
    assign alloc_go = accept && (kind == fpba_pkg::KIND_REQUEST);

    // candidate leaving the last cell decides the allocation
    assign write_back = tail.live && tail.found;
    assign room_new   = tail.room - need_reg;
    // loads happen only while idle, write-back only while scanning
    assign wr_data    = write_back ? room_new : amount;

    always_comb
    begin
        done_next        = load_we || tail.live;
        granted_next     = write_back;
        block_index_next = write_back ? tail.idx[fpba_pkg::SLOT_W-1:0] : '0;
        room_left_next   = write_back ? room_new : '0;
    end

    // row of cells, one per table entry
    for (genvar j = 0; j < MAX_BLOCKS; j++)
    begin : g_cell
        logic cell_live;
        logic cell_wr;

        assign cell_live    = (fpba_pkg::TOK_IDX_W'(j) < fpba_pkg::TOK_IDX_W'(active_reg));
        assign cell_wr      = (load_we
                               && (fpba_pkg::TOK_IDX_W'(slot) == fpba_pkg::TOK_IDX_W'(j)))
                              || (write_back && (tail.idx == fpba_pkg::TOK_IDX_W'(j)));
        assign live_bits[j] = tok[j+1].live;

        fpba_cell #(
            .INDEX (j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .live_en (cell_live),
            .policy  (policy_reg),
            .need    (need_reg),
            .wr_en   (cell_wr),
            .wr_data (wr_data),
            .tok_in  (tok[j]),
            .tok_out (tok[j+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fpba_pkg::ST_IDLE;
            policy_reg      <= fpba_pkg::POLICY_FIRST;
            active_reg      <= fpba_pkg::ACTIVE_RESET;
            inject_reg      <= 1'b0;
            done_reg        <= 1'b0;
            granted_reg     <= 1'b0;
            block_index_reg <= '0;
            room_left_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            inject_reg      <= alloc_go;
            done_reg        <= done_next;
            granted_reg     <= granted_next;
            block_index_reg <= block_index_next;
            room_left_reg   <= room_left_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fpba_pkg::REG_POLICY: policy_reg <= cfg_data[0];
                    fpba_pkg::REG_ACTIVE: active_reg <= cfg_data;
                    default:              active_reg <= active_reg;
                endcase
            end
        end
    end

    // requested size held for the whole scan
    always_ff @(posedge clk)
    begin
        if (alloc_go)
        begin
            need_reg <= amount;
        end
    end

    assign done        = done_reg;
    assign granted     = granted_reg;
    assign block_index = block_index_reg;
    assign room_left   = room_left_reg;

`ifndef NO_ASSERTIONS
    // at most one search candidate in the row of cells
    a_one_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live_bits))
        else $error("more than one search candidate in flight");

    // a result is never shown while a search is still running
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // a grant only comes with a result strobe
    a_grant_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        granted |-> done)
        else $error("grant without result strobe");

    // an allocation's result strobe follows the rise of busy after the full scan
    a_scan_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ##(MAX_BLOCKS+1) done)
        else $error("allocation result missing at expected cycle");

    // nothing leaves the chain unless a search is running
    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.live |-> busy)
        else $error("candidate left the chain while idle");
`endif

endmodule
